### sv/gps_pkg.sv
`default_nettype none

package gps_pkg;

    // Default width of the number under test.
    localparam int unsigned NUMBER_WIDTH_DEF = 16;

    // Bit count of a field of the given bit count, rounded up to whole bytes.
    function automatic int unsigned byte_bits(input int unsigned bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

`default_nettype wire

### sv/gps_mod_unit.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module gps_mod_unit #(
    parameter int unsigned NUMBER_WIDTH = gps_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [NUMBER_WIDTH-1:0] i_dividend,
    input  wire logic [NUMBER_WIDTH-1:0] i_divisor,
    output logic                         o_done,
    output logic [NUMBER_WIDTH-1:0]      o_rem
);

    localparam int unsigned CNT_W = $clog2(NUMBER_WIDTH + 1);

    logic                    r_busy;
    logic [CNT_W-1:0]        r_cnt;
    logic [NUMBER_WIDTH-1:0] r_a;
    logic [NUMBER_WIDTH-1:0] r_b;
    logic [NUMBER_WIDTH-1:0] r_rem;
    logic                    r_done;

    logic [NUMBER_WIDTH:0]   trial;
    logic                    fits;
    logic [NUMBER_WIDTH-1:0] diff;

    assign trial = {r_rem, r_a[NUMBER_WIDTH-1]};
    assign fits  = trial >= {1'b0, r_b};
    // trial - b < b whenever it fits, so the low bits carry the whole difference
    assign diff  = trial[NUMBER_WIDTH-1:0] - r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUMBER_WIDTH);
                r_a    <= i_dividend;
                r_b    <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_a   <= {r_a[NUMBER_WIDTH-2:0], 1'b0};
                r_rem <= fits ? diff : trial[NUMBER_WIDTH-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### sv/gps_prime_test.sv
`default_nettype none

// Trial division sequencer: divides by d = 2, 3, ... while d*d <= v.
module gps_prime_test #(
    parameter int unsigned NUMBER_WIDTH = gps_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [NUMBER_WIDTH-1:0] i_value,
    output logic                         o_done,
    output logic                         o_prime
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT
    } t_state;

    t_state                  r_state;
    logic [NUMBER_WIDTH-1:0] r_v;
    logic [NUMBER_WIDTH-1:0] r_d;
    logic [NUMBER_WIDTH:0]   r_sq;
    logic                    r_mod_start;
    logic                    r_done;
    logic                    r_prime;

    logic                    mod_done;
    logic [NUMBER_WIDTH-1:0] mod_rem;

    gps_mod_unit #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_start),
        .i_dividend (r_v),
        .i_divisor  (r_d),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mod_start <= 1'b0;
            r_done      <= 1'b0;
            r_prime     <= 1'b0;
        end else begin
            r_mod_start <= 1'b0;
            r_done      <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_v  <= i_value;
                        r_d  <= NUMBER_WIDTH'(2);
                        r_sq <= (NUMBER_WIDTH + 1)'(4);
                        if (i_value < NUMBER_WIDTH'(2)) begin
                            r_done  <= 1'b1;
                            r_prime <= 1'b0;
                        end else begin
                            r_state <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (r_sq > {1'b0, r_v}) begin
                        r_done  <= 1'b1;
                        r_prime <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_mod_start <= 1'b1;
                        r_state     <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (mod_done) begin
                        if (mod_rem == '0) begin
                            r_done  <= 1'b1;
                            r_prime <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            // (d+1)^2 = d^2 + 2d + 1
                            r_sq    <= r_sq + {r_d, 1'b1};
                            r_d     <= r_d + NUMBER_WIDTH'(1);
                            r_state <= ST_CHECK;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_prime = r_prime;

endmodule

`default_nettype wire

### sv/goldbach_prime_split.sv
`default_nettype none

// Channel   Dir  Bits (low to high)
// s_axis    in   tdata: number
// m_axis    out  tdata: number_is_prime, split_found, smaller_prime, larger_prime
//
// Each trial division runs in the shared remainder unit; a prime v needs
// floor(sqrt(v)) - 1 of them. An item tests n, then p = 2, 3, ... and n-p until a pair
// is found or p passes n/2.
// Synchronous active-low reset returns every sequencer to idle.
// s_axis_tready is high only while no item is in work; a held result stalls only the finish.
module goldbach_prime_split #(
    parameter int unsigned NUMBER_WIDTH = gps_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      s_axis_tvalid,
    output logic                                           s_axis_tready,
    // number
    input  wire logic [gps_pkg::byte_bits(NUMBER_WIDTH)-1:0] s_axis_tdata,
    output logic                                           m_axis_tvalid,
    input  wire logic                                      m_axis_tready,
    // number_is_prime, split_found, smaller_prime, larger_prime
    output logic [gps_pkg::byte_bits(2*NUMBER_WIDTH+1)-1:0] m_axis_tdata
);

    localparam int unsigned OUT_BITS = 2 * NUMBER_WIDTH + 1;
    localparam int unsigned OUT_W    = gps_pkg::byte_bits(OUT_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN_N,
        ST_RUN_P,
        ST_RUN_Q,
        ST_DONE
    } t_state;

    t_state                    r_state;
    logic [NUMBER_WIDTH-1:0]   r_n;
    logic [NUMBER_WIDTH-1:0]   r_p;
    logic                      r_is_prime;
    logic                      r_found;
    logic                      r_pt_start;
    logic                      r_out_valid;
    logic [OUT_BITS-1:0]       r_out;

    logic [NUMBER_WIDTH-1:0]   half;
    logic [NUMBER_WIDTH-1:0]   q;
    logic [NUMBER_WIDTH-1:0]   p_next;
    logic [NUMBER_WIDTH-1:0]   pt_value;
    logic                      pt_done;
    logic                      pt_prime;
    logic                      in_accept;

    assign half      = r_n >> 1;
    assign q         = r_n - r_p;
    assign p_next    = r_p + NUMBER_WIDTH'(1);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        unique case (r_state)
            ST_RUN_P: pt_value = r_p;
            ST_RUN_Q: pt_value = q;
            default:  pt_value = r_n;
        endcase
    end

    gps_prime_test #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_prime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_pt_start),
        .i_value (pt_value),
        .o_done  (pt_done),
        .o_prime (pt_prime)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pt_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pt_start <= 1'b0;
            // in ST_DONE the output register is handled below
            if (m_axis_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_n        <= s_axis_tdata[NUMBER_WIDTH-1:0];
                        r_pt_start <= 1'b1;
                        r_state    <= ST_RUN_N;
                    end
                end
                ST_RUN_N: begin
                    if (pt_done) begin
                        r_is_prime <= pt_prime;
                        r_found    <= 1'b0;
                        r_p        <= NUMBER_WIDTH'(2);
                        if (half < NUMBER_WIDTH'(2)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_pt_start <= 1'b1;
                            r_state    <= ST_RUN_P;
                        end
                    end
                end
                ST_RUN_P, ST_RUN_Q: begin
                    if (pt_done) begin
                        priority if (pt_prime && r_state == ST_RUN_Q) begin
                            r_found <= 1'b1;
                            r_state <= ST_DONE;
                        end else if (pt_prime) begin
                            r_pt_start <= 1'b1;
                            r_state    <= ST_RUN_Q;
                        end else if (p_next > half) begin
                            r_state <= ST_DONE;
                        end else begin
                            // advance to the next candidate
                            r_p        <= p_next;
                            r_pt_start <= 1'b1;
                            r_state    <= ST_RUN_P;
                        end
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_found
                            ? {q, r_p[NUMBER_WIDTH-2:0], 1'b1, r_is_prime}
                            : {{(OUT_BITS - 2){1'b0}}, 1'b0, r_is_prime};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, r_out};

endmodule

`default_nettype wire
